>>> rtl/wmme_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the window minimum / mean excess block
package wmme_pkg;

    localparam int SAMPLE_W = 32;

    localparam logic [SAMPLE_W-1:0] NO_EST_MEAN = {SAMPLE_W{1'b1}};

    typedef logic [SAMPLE_W-1:0] sample_t;

    // head of the request queue as seen by the engine
    typedef struct packed {
        logic    valid;
        sample_t sample;
    } wmme_req_t;

endpackage

>>> rtl/window_min_mean_excess.sv
`timescale 1ns / 1ps
// top level: request queue in front of the ring scan and division engine
//
//  channel  handshake               payload
//  -------  ----------------------  -------------------------------------
//  input    in_valid / in_stall     sample
//  output   out_valid / out_stall   window_min, mean_excess, no_estimate
//
// one request holds the engine for the one-read-per-cycle scan of the ring and a stepped
// reciprocal multiply for the division by WINDOW; a zero minimum skips the multiply
// reset clears every ring slot at once through per-slot valid bits, no clearing pass
// a two-entry queue takes requests while the engine works; a finished result waits
// in the output register while the next request is written and scanned
module window_min_mean_excess
    import wmme_pkg::*;
#(
    parameter int WINDOW = 100
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  sample_t sample,
    output logic    out_valid,
    input  logic    out_stall,
    output sample_t window_min,
    output sample_t mean_excess,
    output logic    no_estimate
);

    wmme_req_t head;
    logic      pop;

    wmme_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .head     (head),
        .pop      (pop)
    );

    wmme_engine #(
        .WINDOW (WINDOW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .window_min  (window_min),
        .mean_excess (mean_excess),
        .no_estimate (no_estimate)
    );

endmodule

>>> rtl/wmme_queue.sv
`timescale 1ns / 1ps
// front end: two-entry request queue that takes samples off the input channel
module wmme_queue
    import wmme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  sample_t   sample,
    output wmme_req_t head,
    input  logic      pop
);

    logic [SAMPLE_W-1:0] slot_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic                push;
    logic                take;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign take     = pop && (count_reg != 2'd0);

    assign head.valid  = (count_reg != 2'd0);
    assign head.sample = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, take})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/wmme_div.sv
`timescale 1ns / 1ps
// division by the constant window length through a multi-cycle reciprocal multiply
module wmme_div
    import wmme_pkg::*;
#(
    parameter int WINDOW = 100,
    parameter int SUM_W  = 39
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int IDX_W = $clog2(WINDOW);
    // dividend stays below 2^SUM_W, so ceil(2^(SUM_W + IDX_W) / WINDOW) gives exact quotients
    localparam int SHIFT = SUM_W + IDX_W;
    localparam int M_W   = SUM_W + 1;
    localparam int P_W   = SUM_W + M_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);
    localparam logic [2:0] LAST_STEP = 3'd4;

    logic                busy_reg;
    logic                done_reg;
    logic [2:0]          step_reg;
    logic [SUM_W-1:0]    num_reg;
    logic [63:0]         pp_reg;
    logic [1:0]          pp_sh_reg;
    logic [P_W-1:0]      acc_reg;
    logic [63:0]         num_ext;
    logic [SAMPLE_W-1:0] op_a;
    logic [SAMPLE_W-1:0] op_b;
    logic [P_W-1:0]      pp_term;

    // partial products: low x low, low x high, high x low, high x high
    assign num_ext  = 64'(num_reg);
    assign op_a     = step_reg[1] ? num_ext[63:32] : num_ext[31:0];
    assign op_b     = step_reg[0] ? RECIP[63:32] : RECIP[31:0];
    assign done     = done_reg;
    assign quotient = SUM_W'(acc_reg[P_W-1:SHIFT]);

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_term = P_W'(pp_reg);
            2'd1:    pp_term = P_W'(pp_reg) << 32;
            default: pp_term = P_W'(pp_reg) << 64;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    // one partial product per step, registered in pp_reg and then added into the total
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != LAST_STEP)
            begin
                pp_reg    <= op_a * op_b;
                pp_sh_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
            end
            if (step_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_term;
            end
        end
    end

endmodule

>>> rtl/wmme_engine.sv
`timescale 1ns / 1ps
// back end: sample ring, min and sum scan, excess division, result register
module wmme_engine
    import wmme_pkg::*;
#(
    parameter int WINDOW = 100
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  wmme_req_t head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output sample_t   window_min,
    output sample_t   mean_excess,
    output logic      no_estimate
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int SUM_W = SAMPLE_W + IDX_W;
    localparam logic [IDX_W:0]   WIN_CNT  = (IDX_W + 1)'(WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MULT,
        S_START,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    wr_slot_reg;
    logic [WINDOW-1:0]   entry_vld_reg;
    logic [IDX_W:0]      issue_reg;
    logic                rd_pend_reg;
    sample_t             min_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    prod_reg;
    sample_t             res_mean_reg;
    logic                res_noest_reg;
    logic                out_valid_reg;
    sample_t             out_min_reg;
    sample_t             out_mean_reg;
    logic                out_noest_reg;

    sample_t             ring_mem [WINDOW];
    sample_t             rd_data_reg;
    logic                rd_vld_reg;

    logic                wr_en;
    logic                issuing;
    logic [IDX_W-1:0]    rd_addr;
    sample_t             entry;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_quot;
    logic [SUM_W-1:0]    excess_total;

    assign wr_en     = (state_reg == S_IDLE) && head.valid;
    assign pop       = wr_en;
    assign issuing   = (issue_reg < WIN_CNT);
    assign rd_addr   = issuing ? issue_reg[IDX_W-1:0] : '0;
    // slots never written since reset read as zero
    assign entry     = rd_vld_reg ? rd_data_reg : '0;
    assign div_start = (state_reg == S_START);
    // sum of (entry - min) equals sum of entries minus WINDOW * min
    assign excess_total = sum_reg - prod_reg;

    assign out_valid   = out_valid_reg;
    assign window_min  = out_min_reg;
    assign mean_excess = out_mean_reg;
    assign no_estimate = out_noest_reg;

    wmme_div #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (excess_total),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_slot_reg] <= head.sample;
        end
        rd_data_reg <= ring_mem[rd_addr];
        rd_vld_reg  <= entry_vld_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_slot_reg   <= '0;
            entry_vld_reg <= '0;
            issue_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result loads as soon as the output register is free or being taken
            if ((state_reg == S_DONE) && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        entry_vld_reg[wr_slot_reg] <= 1'b1;
                        wr_slot_reg <= (wr_slot_reg == LAST_IDX) ?
                                       '0 : wr_slot_reg + IDX_W'(1);
                        issue_reg   <= '0;
                        rd_pend_reg <= 1'b0;
                        min_reg     <= '1;
                        sum_reg     <= '0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (issuing)
                    begin
                        issue_reg <= issue_reg + (IDX_W + 1)'(1);
                    end
                    rd_pend_reg <= issuing;
                    if (rd_pend_reg)
                    begin
                        if (entry < min_reg)
                        begin
                            min_reg <= entry;
                        end
                        sum_reg <= sum_reg + SUM_W'(entry);
                    end
                    else if (!issuing)
                    begin
                        state_reg <= S_MULT;
                    end
                end
                S_MULT:
                begin
                    if (min_reg == '0)
                    begin
                        res_mean_reg  <= NO_EST_MEAN;
                        res_noest_reg <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        prod_reg  <= SUM_W'(min_reg) * SUM_W'(WINDOW);
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        // excess total is below WINDOW * 2^32, so the quotient fits
                        res_mean_reg  <= div_quot[SAMPLE_W-1:0];
                        res_noest_reg <= 1'b0;
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_min_reg   <= min_reg;
                        out_mean_reg  <= res_mean_reg;
                        out_noest_reg <= res_noest_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> test/window_min_mean_excess_checker.sv
`timescale 1ns / 1ps
// checker for window_min_mean_excess: mirrors the sample ring and compares every result
module window_min_mean_excess_checker
    import wmme_pkg::*;
#(
    parameter int WINDOW = 100
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_stall,
    input  sample_t sample,
    input  logic    out_valid,
    input  logic    out_stall,
    input  sample_t window_min,
    input  sample_t mean_excess,
    input  logic    no_estimate,
    output int      fail_count,
    output int      pending,
    output int      results_seen
);

    typedef struct packed {
        sample_t lowest;
        sample_t excess;
        logic    no_est;
    } window_stats_t;

    sample_t       ring [WINDOW];
    int            slot;
    window_stats_t stats_q [$];

    // minimum over the whole ring and the mean excess above it
    function automatic window_stats_t window_stats();
        window_stats_t s;
        logic [63:0]   total;
        s.lowest = ring[0];
        for (int k = 1; k < WINDOW; k++)
        begin
            if (ring[k] < s.lowest)
                s.lowest = ring[k];
        end
        if (s.lowest == '0)
        begin
            s.excess = NO_EST_MEAN;
            s.no_est = 1'b1;
        end
        else
        begin
            total = '0;
            for (int k = 0; k < WINDOW; k++)
                total = total + 64'(ring[k] - s.lowest);
            total = total / 64'(WINDOW);
            s.excess = total[SAMPLE_W-1:0];
            s.no_est = 1'b0;
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        window_stats_t want;
        if (!rst_n)
        begin
            foreach (ring[k])
                ring[k] = '0;
            slot = 0;
            stats_q.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                ring[slot] = sample;
                slot = (slot == WINDOW - 1) ? 0 : slot + 1;
                stats_q.push_back(window_stats());
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (stats_q.size() == 0)
                begin
                    $display("%0t: result with no request pending: min %h mean %h flag %b",
                             $time, window_min, mean_excess, no_estimate);
                    fail_count++;
                end
                else
                begin
                    want = stats_q.pop_front();
                    if (window_min !== want.lowest)
                    begin
                        $display("%0t: window_min expected %h, actual %h",
                                 $time, want.lowest, window_min);
                        fail_count++;
                    end
                    if (mean_excess !== want.excess)
                    begin
                        $display("%0t: mean_excess expected %h, actual %h",
                                 $time, want.excess, mean_excess);
                        fail_count++;
                    end
                    if (no_estimate !== want.no_est)
                    begin
                        $display("%0t: no_estimate expected %b, actual %b",
                                 $time, want.no_est, no_estimate);
                        fail_count++;
                    end
                end
            end
            pending = stats_q.size();
        end
    end

endmodule

>>> test/window_min_mean_excess_tb.sv
`timescale 1ns / 1ps
// testbench top for window_min_mean_excess: stimulus, output back-pressure and verdict
module window_min_mean_excess_tb
    import wmme_pkg::*;
();

    localparam int WINDOW       = 100;
    localparam int RANDOM_ITEMS = 1935;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 300;

    typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EXTREME} spread_mode_t;

    localparam sample_t EDGE_SAMPLES [12] = '{
        32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
        32'h7fff_ffff, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0000,
        32'hffff_fffe, 32'h0000_0002, 32'h0001_0000, 32'hffff_0000
    };

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    sample_t sample = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    sample_t window_min;
    sample_t mean_excess;
    logic    no_estimate;

    int fail_count;
    int pending;
    int results_seen;
    int quiet_cycles = 0;
    bit idle_on = 1'b1;

    window_min_mean_excess #(.WINDOW(WINDOW)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .window_min  (window_min),
        .mean_excess (mean_excess),
        .no_estimate (no_estimate)
    );

    window_min_mean_excess_checker #(.WINDOW(WINDOW)) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .window_min   (window_min),
        .mean_excess  (mean_excess),
        .no_estimate  (no_estimate),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one request, with an occasional gap in front, and wait for it to be taken
    task automatic push_sample(input sample_t v);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // a zero now and then knocks the window back to no estimate
    function automatic sample_t pick_sample(spread_mode_t mode, sample_t base, sample_t spread);
        sample_t v;
        if ($urandom_range(0, 149) == 0)
            return '0;
        case (mode)
            SPREAD_WIDE:    v = $urandom;
            SPREAD_NARROW:  v = base + $urandom_range(0, spread);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_0001;
                    1:       v = 32'hffff_fffe;
                    default: v = 32'hffff_ffff;
                endcase
            end
        endcase
        return v;
    endfunction

    initial
    begin
        spread_mode_t mode;
        int           seg_left;
        sample_t      base;
        sample_t      spread;
        mode     = SPREAD_WIDE;
        seg_left = 0;
        base     = 32'h1;
        spread   = 32'h3;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // window not yet full: field extremes while reset zeros remain in the ring
        foreach (EDGE_SAMPLES[i])
            push_sample(EDGE_SAMPLES[i]);
        pause_until_drained();

        // segments long enough to fill the window with one kind of data
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                mode     = spread_mode_t'($urandom_range(0, 2));
                seg_left = $urandom_range(120, 300);
                base     = $urandom_range(1, 32'hfff0_0000);
                case ($urandom_range(0, 2))
                    0:       spread = 32'h3;
                    1:       spread = 32'd1000;
                    default: spread = 32'hffff;
                endcase
            end
            seg_left--;
            idle_on = (n < RANDOM_ITEMS - 150);
            if (n == RANDOM_ITEMS / 2)
                pause_until_drained();
            push_sample(pick_sample(mode, base, spread));
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // output side: random stall bursts plus one long hold to back up the queue
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 300)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
